### rtl/lsd_radix_sort_fixed_keys_macros.svh
// ----------------------------------------------------------------------------
// LSD radix sort assertion macros
// Concurrent assertion helpers shared by the sorter RTL.
// ----------------------------------------------------------------------------
`ifndef LSD_RADIX_SORT_FIXED_KEYS_MACROS_SVH
`define LSD_RADIX_SORT_FIXED_KEYS_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LRS_ASSERT_IMP(label, clk_s, rst_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("lsd radix sort: implication check failed");

// next-cycle implication
`define LRS_ASSERT_NEXT(label, clk_s, rst_s, pre, post) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("lsd radix sort: next-cycle check failed");

`else

`define LRS_ASSERT_IMP(label, clk_s, rst_s, pre, post)
`define LRS_ASSERT_NEXT(label, clk_s, rst_s, pre, post)

`endif

`endif

### rtl/lrsfk_pkg.sv
// ----------------------------------------------------------------------------
// lrsfk_pkg
// Sizes, row word types and controller states of the LSD radix sorter.
// ----------------------------------------------------------------------------
package lrsfk_pkg;

    localparam int MAX_ROWS      = 64;
    localparam int MAX_KEY_BYTES = 8;
    localparam int BUCKETS       = 256;

    localparam int KEY_W   = 64;
    localparam int KB_W    = 4;
    localparam int ROW_AW  = $clog2(MAX_ROWS);
    localparam int CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int BKT_AW  = $clog2(BUCKETS);
    localparam int SCAN_W  = $clog2(BUCKETS + 1);
    localparam int PASS_W  = $clog2(MAX_KEY_BYTES);

    typedef struct packed {
        logic [ROW_AW-1:0] idx;
        logic [KEY_W-1:0]  key;
    } row_t;

    typedef struct packed {
        logic [ROW_AW-1:0] idx;
        logic [KEY_W-1:0]  key;
        logic              last;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_LOAD    = 5'b00001,
        ST_COUNT   = 5'b00010,
        ST_SCAN    = 5'b00100,
        ST_SCATTER = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

endpackage

### rtl/lsd_radix_sort_fixed_keys.sv
// ----------------------------------------------------------------------------
// lsd_radix_sort_fixed_keys
// Batch LSD radix sorter: loads up to MAX_ROWS keyed rows, sorts them with one
// stable 256-bucket counting pass per key byte and streams them out in order.
// ----------------------------------------------------------------------------
// Load: one row per cycle while in LOAD (in_ready is low while sorting). After the
// last row, each key byte costs one pass: count sweep, 256-bucket prefix scan, then
// scatter, reading one row or one bucket counter per cycle.
// Output then streams one word per cycle while out_ready is high.
// Reset: async active low; batch empty, key_bytes = MAX_KEY_BYTES, row memories
// undefined, bucket valid bits cleared.
`include "lsd_radix_sort_fixed_keys_macros.svh"

module lsd_radix_sort_fixed_keys
    import lrsfk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [KB_W-1:0]   cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KEY_W-1:0]  key_value,
    input  logic              last_row,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROW_AW-1:0] row_index,
    output logic [KEY_W-1:0]  sorted_key,
    output logic              last_out
);

    // memories
    row_t             mem_a [MAX_ROWS];
    row_t             mem_b [MAX_ROWS];
    logic [CNT_W-1:0] cnt_mem [BUCKETS];
    logic [BUCKETS-1:0] cnt_vld_reg;

    row_t              a_q;
    row_t              b_q;
    logic [CNT_W-1:0]  cnt_q;
    logic              cnt_vq;

    // control state
    state_t            state_reg, state_next;
    logic [KB_W-1:0]   key_bytes_reg;
    logic [CNT_W-1:0]  rows_loaded_reg, rows_loaded_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [SCAN_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              src_is_a_reg, src_is_a_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic              s1_vld_reg, s1_vld_next;
    logic              s2_vld_reg, s2_vld_next;
    logic [BKT_AW-1:0] s2_bkt_reg, s2_bkt_next;
    row_t              s2_row_reg;
    logic              fwd_vld_reg;
    logic [BKT_AW-1:0] fwd_bkt_reg;
    logic [CNT_W-1:0]  fwd_val_reg;
    logic              ret_vld_reg, ret_vld_next;
    logic              ret_last_reg, ret_last_next;
    logic [1:0]        occ_reg, occ_next;
    logic              out_vld_reg, out_vld_next;
    logic              skid_vld_reg, skid_vld_next;
    out_word_t         out_data_reg, out_data_next;
    out_word_t         skid_data_reg, skid_data_next;

    // datapath
    logic [KB_W-1:0]   kb;
    logic              in_fire;
    logic              out_fire;
    logic              out_free;
    row_t              src_q;
    logic [BKT_AW-1:0] s1_bkt;
    logic              fwd_hit;
    logic [CNT_W-1:0]  cnt_eff;
    logic              row_issue;
    logic              scan_issue;
    logic [ROW_AW-1:0] row_ra;
    logic [BKT_AW-1:0] cnt_ra;
    logic              cnt_we;
    logic [BKT_AW-1:0] cnt_wa;
    logic [CNT_W-1:0]  cnt_wd;
    logic              vld_clr;
    logic              mem_a_we;
    logic [ROW_AW-1:0] mem_a_wa;
    row_t              mem_a_wd;
    logic              mem_b_we;
    out_word_t         ret_data;

    assign kb       = (key_bytes_reg > KB_W'(MAX_KEY_BYTES)) ? KB_W'(MAX_KEY_BYTES)
                                                             : key_bytes_reg;
    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_vld_reg && out_ready;
    assign out_free = !out_vld_reg || out_fire;

    assign src_q   = src_is_a_reg ? a_q : b_q;
    assign s1_bkt  = src_q.key[{pass_reg, 3'b000} +: BKT_AW];
    // the write landing at the same edge as our read is not seen by the read
    assign fwd_hit = fwd_vld_reg && (fwd_bkt_reg == s2_bkt_reg);
    assign cnt_eff = fwd_hit ? fwd_val_reg : (cnt_vq ? cnt_q : '0);

    assign ret_data = '{idx: src_q.idx, key: src_q.key, last: ret_last_reg};

    always_comb
    begin
        row_issue  = 1'b0;
        scan_issue = 1'b0;
        case (state_reg)
            ST_COUNT, ST_SCATTER:
            begin
                row_issue = (rd_cnt_reg != n_reg);
            end
            ST_SCAN:
            begin
                scan_issue = (scan_cnt_reg != SCAN_W'(BUCKETS));
            end
            ST_EMIT:
            begin
                row_issue = (rd_cnt_reg != n_reg) && ((occ_reg != 2'd2) || out_fire);
            end
            default:
            begin
                row_issue  = 1'b0;
                scan_issue = 1'b0;
            end
        endcase
    end

    assign row_ra = rd_cnt_reg[ROW_AW-1:0];
    assign cnt_ra = (state_reg == ST_SCAN) ? scan_cnt_reg[BKT_AW-1:0] : s1_bkt;

    // bucket counter write stage
    always_comb
    begin
        cnt_we = s2_vld_reg;
        cnt_wa = s2_bkt_reg;
        if (state_reg == ST_SCAN)
        begin
            cnt_wd = run_reg;
        end
        else
        begin
            cnt_wd = cnt_eff + CNT_W'(1);
        end
    end

    // row buffer writes: load into A, scatter into the buffer opposite src
    always_comb
    begin
        mem_a_we = 1'b0;
        mem_a_wa = s2_row_reg.idx;
        mem_a_wd = s2_row_reg;
        mem_b_we = 1'b0;
        if (in_fire && (rows_loaded_reg != CNT_W'(MAX_ROWS)))
        begin
            mem_a_we = 1'b1;
            mem_a_wa = rows_loaded_reg[ROW_AW-1:0];
            mem_a_wd = '{idx: rows_loaded_reg[ROW_AW-1:0], key: key_value};
        end
        else if (s2_vld_reg && (state_reg == ST_SCATTER))
        begin
            mem_a_wa = cnt_eff[ROW_AW-1:0];
            mem_a_we = !src_is_a_reg;
            mem_b_we = src_is_a_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        rows_loaded_next = rows_loaded_reg;
        n_next           = n_reg;
        rd_cnt_next      = rd_cnt_reg + CNT_W'(row_issue);
        scan_cnt_next    = scan_cnt_reg + SCAN_W'(scan_issue);
        pass_next        = pass_reg;
        src_is_a_next    = src_is_a_reg;
        run_next         = run_reg;
        vld_clr          = 1'b0;
        s1_vld_next      = row_issue && (state_reg != ST_EMIT);
        s2_vld_next      = s1_vld_reg || scan_issue;
        s2_bkt_next      = (state_reg == ST_SCAN) ? scan_cnt_reg[BKT_AW-1:0] : s1_bkt;
        ret_vld_next     = row_issue && (state_reg == ST_EMIT);
        ret_last_next    = ((rd_cnt_reg + CNT_W'(1)) == n_reg);
        occ_next         = occ_reg + 2'(ret_vld_next) - 2'(out_fire);

        if ((state_reg == ST_SCAN) && s2_vld_reg)
        begin
            run_next = run_reg + cnt_eff;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (rows_loaded_reg != CNT_W'(MAX_ROWS))
                    begin
                        rows_loaded_next = rows_loaded_reg + CNT_W'(1);
                    end
                    if (last_row)
                    begin
                        n_next           = (rows_loaded_reg != CNT_W'(MAX_ROWS))
                                           ? rows_loaded_reg + CNT_W'(1) : rows_loaded_reg;
                        rows_loaded_next = '0;
                        rd_cnt_next      = '0;
                        pass_next        = '0;
                        src_is_a_next    = 1'b1;
                        if (kb == '0)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            vld_clr    = 1'b1;
                            state_next = ST_COUNT;
                        end
                    end
                end
            end
            ST_COUNT:
            begin
                if (!row_issue && !s1_vld_reg && !s2_vld_reg)
                begin
                    scan_cnt_next = '0;
                    run_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!scan_issue && !s2_vld_reg)
                begin
                    rd_cnt_next = '0;
                    state_next  = ST_SCATTER;
                end
            end
            ST_SCATTER:
            begin
                if (!row_issue && !s1_vld_reg && !s2_vld_reg)
                begin
                    src_is_a_next = !src_is_a_reg;
                    pass_next     = pass_reg + PASS_W'(1);
                    rd_cnt_next   = '0;
                    if (({1'b0, pass_reg} + KB_W'(1)) == kb)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        vld_clr    = 1'b1;
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_EMIT:
            begin
                if ((rd_cnt_reg == n_reg) && (occ_reg == '0))
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // output register with skid word
    always_comb
    begin
        out_vld_next   = out_vld_reg;
        skid_vld_next  = skid_vld_reg;
        out_data_next  = out_data_reg;
        skid_data_next = skid_data_reg;
        if (out_free)
        begin
            if (skid_vld_reg)
            begin
                out_data_next = skid_data_reg;
                out_vld_next  = 1'b1;
                if (ret_vld_reg)
                begin
                    skid_data_next = ret_data;
                end
                else
                begin
                    skid_vld_next = 1'b0;
                end
            end
            else if (ret_vld_reg)
            begin
                out_data_next = ret_data;
                out_vld_next  = 1'b1;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
        else if (ret_vld_reg)
        begin
            skid_data_next = ret_data;
            skid_vld_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            key_bytes_reg   <= KB_W'(MAX_KEY_BYTES);
            rows_loaded_reg <= '0;
            n_reg           <= '0;
            rd_cnt_reg      <= '0;
            scan_cnt_reg    <= '0;
            pass_reg        <= '0;
            src_is_a_reg    <= 1'b1;
            run_reg         <= '0;
            s1_vld_reg      <= 1'b0;
            s2_vld_reg      <= 1'b0;
            fwd_vld_reg     <= 1'b0;
            ret_vld_reg     <= 1'b0;
            occ_reg         <= '0;
            out_vld_reg     <= 1'b0;
            skid_vld_reg    <= 1'b0;
            cnt_vld_reg     <= '0;
            cnt_vq          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_wr_en)
            begin
                key_bytes_reg <= cfg_wr_data;
            end
            rows_loaded_reg <= rows_loaded_next;
            n_reg           <= n_next;
            rd_cnt_reg      <= rd_cnt_next;
            scan_cnt_reg    <= scan_cnt_next;
            pass_reg        <= pass_next;
            src_is_a_reg    <= src_is_a_next;
            run_reg         <= run_next;
            s1_vld_reg      <= s1_vld_next;
            s2_vld_reg      <= s2_vld_next;
            fwd_vld_reg     <= cnt_we;
            ret_vld_reg     <= ret_vld_next;
            occ_reg         <= occ_next;
            out_vld_reg     <= out_vld_next;
            skid_vld_reg    <= skid_vld_next;
            cnt_vq          <= cnt_vld_reg[cnt_ra];
            // a cleared entry reads as zero until its first write of the pass
            if (vld_clr)
            begin
                cnt_vld_reg <= '0;
            end
            else if (cnt_we)
            begin
                cnt_vld_reg[cnt_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_bkt_reg    <= s2_bkt_next;
        s2_row_reg    <= src_q;
        fwd_bkt_reg   <= cnt_wa;
        fwd_val_reg   <= cnt_wd;
        ret_last_reg  <= ret_last_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_a_we)
        begin
            mem_a[mem_a_wa] <= mem_a_wd;
        end
        a_q <= mem_a[row_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mem_b_we)
        begin
            mem_b[mem_a_wa] <= s2_row_reg;
        end
        b_q <= mem_b[row_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_q <= cnt_mem[cnt_ra];
    end

    assign out_valid  = out_vld_reg;
    assign row_index  = out_data_reg.idx;
    assign sorted_key = out_data_reg.key;
    assign last_out   = out_data_reg.last;

    `LRS_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_reg != 2'd3)
    `LRS_ASSERT_IMP(a_skid_free, clk, rst_n, ret_vld_reg && out_vld_reg && !out_ready, !skid_vld_reg)
    `LRS_ASSERT_IMP(a_scatter_addr, clk, rst_n, s2_vld_reg && (state_reg == ST_SCATTER), cnt_eff < n_reg)
    `LRS_ASSERT_NEXT(a_batch_empty, clk, rst_n, in_valid && in_ready && last_row, rows_loaded_reg == '0)

endmodule

### test/tb_lsd_radix_sort_fixed_keys.sv
// ----------------------------------------------------------------------------
// tb_lsd_radix_sort_fixed_keys
// Loads batches of keyed rows, predicts the stable byte-order sort of each
// batch under the current key width and checks every sorted output word.
// ----------------------------------------------------------------------------
module tb_lsd_radix_sort_fixed_keys
    import lrsfk_pkg::*;
();

    typedef struct {
        logic [KEY_W-1:0] key;
        logic             last;
    } row_in_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [KB_W-1:0]   cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [KEY_W-1:0]  key_value = '0;
    logic              last_row = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ROW_AW-1:0] row_index;
    logic [KEY_W-1:0]  sorted_key;
    logic              last_out;

    row_in_t           pending_rows[$];
    out_word_t         sorted_rows_due[$];

    // predictor state
    logic [KEY_W-1:0]  held_keys [MAX_ROWS];
    int                rows_held = 0;
    logic [KB_W-1:0]   cur_key_bytes = KB_W'(MAX_KEY_BYTES);

    int                snd_idle_pct = 0;
    int                rcv_idle_pct = 0;
    int                errors = 0;
    int                rows_queued = 0;
    bit                hold_armed = 1'b0;
    bit                hold_used = 1'b0;
    int                hold_left = 0;

    lsd_radix_sort_fixed_keys uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_value   (key_value),
        .last_row    (last_row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_index   (row_index),
        .sorted_key  (sorted_key),
        .last_out    (last_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Store one row; on the last row sort the batch stably on its used bytes.
    task automatic load_row_and_predict(input logic [KEY_W-1:0] key, input logic last);
        logic [KEY_W-1:0]  ord_key [MAX_ROWS];
        logic [ROW_AW-1:0] ord_idx [MAX_ROWS];
        logic [KEY_W-1:0]  mask;
        logic [KEY_W-1:0]  tk;
        logic [ROW_AW-1:0] ti;
        out_word_t         w;
        int                kb;
        int                i;
        int                j;
        if (rows_held < MAX_ROWS)
        begin
            held_keys[rows_held] = key;
            rows_held++;
        end
        if (last)
        begin
            kb = (cur_key_bytes > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(cur_key_bytes);
            // zero key bytes gives an all-zero mask: arrival order
            mask = (kb == MAX_KEY_BYTES) ? '1 : ((64'd1 << (8 * kb)) - 64'd1);
            for (i = 0; i < rows_held; i++)
            begin
                ord_key[i] = held_keys[i];
                ord_idx[i] = ROW_AW'(i);
            end
            for (i = 1; i < rows_held; i++)
            begin
                tk = ord_key[i];
                ti = ord_idx[i];
                j = i - 1;
                while (j >= 0 && (ord_key[j] & mask) > (tk & mask))
                begin
                    ord_key[j + 1] = ord_key[j];
                    ord_idx[j + 1] = ord_idx[j];
                    j--;
                end
                ord_key[j + 1] = tk;
                ord_idx[j + 1] = ti;
            end
            for (i = 0; i < rows_held; i++)
            begin
                w.idx  = ord_idx[i];
                w.key  = ord_key[i];
                w.last = (i == rows_held - 1);
                sorted_rows_due.insert(sorted_rows_due.size(), w);
            end
            rows_held = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_rows
        row_in_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            key_value <= '0;
            last_row  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                load_row_and_predict(key_value, last_row);
            if (!in_valid || in_ready)
            begin
                if (pending_rows.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct)
                begin
                    nxt = pending_rows.pop_front();
                    in_valid  <= 1'b1;
                    key_value <= nxt.key;
                    last_row  <= nxt.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_sorted
        out_word_t exp_w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sorted_rows_due.size() == 0)
                begin
                    $display("%0t unexpected word: row_index %0d sorted_key %h last_out %b",
                             $time, row_index, sorted_key, last_out);
                    errors++;
                end
                else
                begin
                    exp_w = sorted_rows_due.pop_front();
                    if (row_index !== exp_w.idx)
                    begin
                        $display("%0t row_index expected %0d actual %0d",
                                 $time, exp_w.idx, row_index);
                        errors++;
                    end
                    if (sorted_key !== exp_w.key)
                    begin
                        $display("%0t sorted_key expected %h actual %h",
                                 $time, exp_w.key, sorted_key);
                        errors++;
                    end
                    if (last_out !== exp_w.last)
                    begin
                        $display("%0t last_out expected %b actual %b",
                                 $time, exp_w.last, last_out);
                        errors++;
                    end
                end
            end
            // long hold-off once output starts, so the block backs up its input
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_armed && !hold_used && out_valid)
            begin
                out_ready <= 1'b0;
                hold_left <= 500;
                hold_used <= 1'b1;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic push_row(input logic [KEY_W-1:0] key, input logic last);
        row_in_t r;
        r.key  = key;
        r.last = last;
        pending_rows.insert(pending_rows.size(), r);
        rows_queued++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int b;
        for (b = 0; b < 8; b++)
        begin
            case ($urandom_range(0, 3))
                0: k[8*b +: 8] = 8'h00;
                1: k[8*b +: 8] = 8'hFF;
                2: k[8*b +: 8] = 8'($urandom_range(0, 2));
                default: k[8*b +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return k;
    endfunction

    task automatic queue_batch(input int n);
        int i;
        for (i = 0; i < n; i++)
            push_row(pick_key(), i == n - 1);
    endtask

    // wait until everything queued is accepted and every word is back
    task automatic drain();
        while (pending_rows.size() != 0 || in_valid || sorted_rows_due.size() != 0)
            @(negedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_key_bytes(input logic [KB_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_key_bytes = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int nb;
        int b;
        logic [KB_W-1:0] kb;
        snd_idle_pct = 21;
        rcv_idle_pct = 77;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset width of 8 bytes: extremes, ties keep arrival order
        push_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_row(64'h0000_0000_0000_0000, 1'b0);
        push_row(64'h0123_4567_89AB_CDEF, 1'b0);
        push_row(64'h0000_0000_0000_0000, 1'b0);
        push_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_row(64'h8000_0000_0000_0000, 1'b0);
        push_row(64'h0000_0000_0000_0001, 1'b1);
        // one-row batch
        push_row(64'hDEAD_BEEF_0000_0042, 1'b1);
        drain();

        // one key byte: upper bits ride along unsorted
        set_key_bytes(4'd1);
        push_row(64'hFF00_0000_0000_0005, 1'b0);
        push_row(64'h0000_0000_0000_0005, 1'b0);
        push_row(64'h1234_0000_0000_00FF, 1'b0);
        push_row(64'h0000_0000_0000_0000, 1'b0);
        push_row(64'hFFFF_FFFF_FFFF_FF00, 1'b1);
        drain();

        // zero key bytes: arrival order
        set_key_bytes(4'd0);
        queue_batch(4);
        drain();

        // width above the maximum acts as full width
        set_key_bytes(4'd15);
        queue_batch(5);
        drain();

        while (rows_queued < 130)
        begin
            if (rows_queued < 30)
            begin
                snd_idle_pct = 21;
                rcv_idle_pct = 77;
            end
            else if (rows_queued < 50)
            begin
                snd_idle_pct = 77;
                rcv_idle_pct = 21;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            case ($urandom_range(0, 5))
                0: kb = 4'd0;
                1: kb = 4'd1;
                2: kb = 4'd8;
                3: kb = 4'd15;
                default: kb = 4'($urandom_range(0, 15));
            endcase
            if (rows_queued >= 50 && !hold_armed)
            begin
                // full batch plus dropped rows, the last one dropped too;
                // a second batch waits behind it during the hold-off
                set_key_bytes(4'd2);
                queue_batch(MAX_ROWS + 3);
                queue_batch($urandom_range(3, 8));
                hold_armed = 1'b1;
            end
            else
            begin
                set_key_bytes(kb);
                nb = $urandom_range(1, 3);
                for (b = 0; b < nb; b++)
                    queue_batch($urandom_range(1, 10));
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
